@@ design/ihex_pkg.sv @@
`timescale 1ns / 1ps

package ihex_pkg;

  typedef enum logic [5:0] {
    PH_COLON = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_ADDR  = 6'b000100,
    PH_TYPE  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CSUM  = 6'b100000
  } phase_t;

  localparam logic [1:0] EV_DATA = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  localparam logic [1:0] ER_FORMAT = 2'd0;
  localparam logic [1:0] ER_TYPE   = 2'd1;
  localparam logic [1:0] ER_RANGE  = 2'd2;
  localparam logic [1:0] ER_CSUM   = 2'd3;

  localparam logic CFG_ROM_SIZE    = 1'b0;
  localparam logic CFG_LOAD_OFFSET = 1'b1;

  localparam int RomSizeWidth = 17;
  localparam int CountOutWidth = 24;

  typedef struct packed {
    logic [1:0]               event_res;
    logic [15:0]              load_address;
    logic [7:0]               data_byte;
    logic [1:0]               error_code;
    logic [CountOutWidth-1:0] byte_count;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.ok  = 1'b1;
      h.val = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

@@ design/intel_hex_record_decoder_top.sv @@
`timescale 1ns / 1ps

// Intel HEX decoder: takes one ASCII character per beat and gives at most one
// result per character (a data byte with its ROM address, end of file with
// the loaded byte count, or an error). Characters are taken one per clock
// cycle: each passes from an input register through the per-character parse
// logic into a result register; throughput is one character per cycle while
// the result side keeps taking beats. After end of file or an error the block
// swallows every further character until reset. Write rom_size and
// load_offset only while the block is idle.
module intel_hex_record_decoder_top
  import ihex_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               character,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               event_res,
  output logic [15:0]              load_address,
  output logic [7:0]               data_byte,
  output logic [1:0]               error_code,
  output logic [CountOutWidth-1:0] byte_count,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [RomSizeWidth-1:0]  cfg_data
);

  logic [RomSizeWidth-1:0] rom_size;
  logic [15:0]             load_offset;

  logic       held_valid;
  logic [7:0] held_char;
  logic       slot_free;
  logic       step;
  logic       res_fire;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size    <= RomSizeWidth'(32768);
      load_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_SIZE:    rom_size    <= cfg_data;
        CFG_LOAD_OFFSET: load_offset <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // advance only when a result, if any, has somewhere to go
  assign step = held_valid && slot_free;

  ihex_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .character  (character),
    .take       (step),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  ihex_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_in     (held_char),
    .rom_size    (rom_size),
    .load_offset (load_offset),
    .res_fire    (res_fire),
    .res         (res)
  );

  ihex_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res_fire),
    .res          (res),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .load_address (load_address),
    .data_byte    (data_byte),
    .error_code   (error_code),
    .byte_count   (byte_count)
  );

endmodule

@@ design/ihex_in_reg.sv @@
`timescale 1ns / 1ps

module ihex_in_reg
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_char
);

  logic       valid_q;
  logic [7:0] char_q;

  // accept a new beat whenever the held one is empty or being consumed
  assign in_ready   = !valid_q || take;
  assign held_valid = valid_q;
  assign held_char  = char_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_q <= character;
    end
  end

endmodule

@@ design/ihex_parser.sv @@
`timescale 1ns / 1ps

module ihex_parser
  import ihex_pkg::*;
#(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              char_in,
  input  logic [RomSizeWidth-1:0] rom_size,
  input  logic [15:0]             load_offset,
  output logic                    res_fire,
  output result_t                 res
);

  phase_t                 phase, phase_next;
  logic [1:0]             digit_count, digit_count_next;
  logic [11:0]            field_shift, field_shift_next;
  logic [7:0]             bytes_left, bytes_left_next;
  logic [15:0]            record_address, record_address_next;
  logic                   record_is_end, record_is_end_next;
  logic [7:0]             running_sum, running_sum_next;
  logic [COUNT_WIDTH-1:0] loaded_count, loaded_count_next;
  logic                   halted, halted_next;

  hex_digit_t  hd;
  logic        blank;
  logic [15:0] val;
  logic        complete;
  logic [15:0] target;
  logic [7:0]  sum_add;

  always_comb begin
    hd       = hex_decode(char_in);
    blank    = is_blank(char_in);
    val      = {field_shift, hd.val};
    complete = (phase == PH_ADDR) ? (digit_count == 2'd3) : (digit_count != 2'd0);
    target   = record_address + load_offset;
    sum_add  = running_sum + val[7:0];
  end

  always_comb begin
    phase_next          = phase;
    digit_count_next    = digit_count;
    field_shift_next    = field_shift;
    bytes_left_next     = bytes_left;
    record_address_next = record_address;
    record_is_end_next  = record_is_end;
    running_sum_next    = running_sum;
    loaded_count_next   = loaded_count;
    halted_next         = halted;
    res_fire            = 1'b0;
    res                 = '0;

    if (step && !halted) begin
      unique case (phase)
        PH_COLON: begin
          if (!blank) begin
            if (char_in != 8'h3A) begin
              halted_next    = 1'b1;
              res_fire       = 1'b1;
              res.event_res  = EV_ERR;
              res.error_code = ER_FORMAT;
            end else begin
              phase_next       = PH_LEN;
              digit_count_next = 2'd0;
              field_shift_next = '0;
              running_sum_next = '0;
            end
          end
        end
        default: begin
          if (digit_count == 2'd0 && blank) begin
            // skip whitespace ahead of a field
          end else if (!hd.ok) begin
            halted_next    = 1'b1;
            res_fire       = 1'b1;
            res.event_res  = EV_ERR;
            res.error_code = ER_FORMAT;
          end else if (!complete) begin
            digit_count_next = 2'(digit_count + 2'd1);
            field_shift_next = val[11:0];
          end else begin
            digit_count_next = 2'd0;
            field_shift_next = '0;
            unique case (phase)
              PH_LEN: begin
                bytes_left_next  = val[7:0];
                running_sum_next = val[7:0];
                phase_next       = PH_ADDR;
              end
              PH_ADDR: begin
                record_address_next = val;
                running_sum_next    = 8'(running_sum + val[15:8] + val[7:0]);
                phase_next          = PH_TYPE;
              end
              PH_TYPE: begin
                if (val[7:0] > 8'd1) begin
                  halted_next    = 1'b1;
                  res_fire       = 1'b1;
                  res.event_res  = EV_ERR;
                  res.error_code = ER_TYPE;
                end else begin
                  record_is_end_next = val[0];
                  running_sum_next   = sum_add;
                  phase_next         = (bytes_left != 8'd0) ? PH_DATA : PH_CSUM;
                end
              end
              PH_DATA: begin
                if ({1'b0, target} >= rom_size) begin
                  halted_next    = 1'b1;
                  res_fire       = 1'b1;
                  res.event_res  = EV_ERR;
                  res.error_code = ER_RANGE;
                end else begin
                  running_sum_next = sum_add;
                  if (loaded_count != {COUNT_WIDTH{1'b1}}) begin
                    loaded_count_next = loaded_count + 1'b1;
                  end
                  record_address_next = record_address + 16'd1;
                  bytes_left_next     = bytes_left - 8'd1;
                  if (bytes_left == 8'd1) begin
                    phase_next = PH_CSUM;
                  end
                  res_fire         = 1'b1;
                  res.event_res    = EV_DATA;
                  res.load_address = target;
                  res.data_byte    = val[7:0];
                end
              end
              PH_CSUM: begin
                running_sum_next = sum_add;
                if (sum_add != 8'd0) begin
                  halted_next    = 1'b1;
                  res_fire       = 1'b1;
                  res.event_res  = EV_ERR;
                  res.error_code = ER_CSUM;
                end else begin
                  phase_next = PH_COLON;
                  if (record_is_end) begin
                    halted_next    = 1'b1;
                    res_fire       = 1'b1;
                    res.event_res  = EV_END;
                    res.byte_count = CountOutWidth'(loaded_count);
                  end
                end
              end
              default: begin
                halted_next    = 1'b1;
                res_fire       = 1'b1;
                res.event_res  = EV_ERR;
                res.error_code = ER_FORMAT;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COLON;
      digit_count    <= '0;
      field_shift    <= '0;
      bytes_left     <= '0;
      record_address <= '0;
      record_is_end  <= 1'b0;
      running_sum    <= '0;
      loaded_count   <= '0;
      halted         <= 1'b0;
    end else begin
      phase          <= phase_next;
      digit_count    <= digit_count_next;
      field_shift    <= field_shift_next;
      bytes_left     <= bytes_left_next;
      record_address <= record_address_next;
      record_is_end  <= record_is_end_next;
      running_sum    <= running_sum_next;
      loaded_count   <= loaded_count_next;
      halted         <= halted_next;
    end
  end

endmodule

@@ design/ihex_out_reg.sv @@
`timescale 1ns / 1ps

module ihex_out_reg
  import ihex_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  result_t                  res,
  output logic                     slot_free,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               event_res,
  output logic [15:0]              load_address,
  output logic [7:0]               data_byte,
  output logic [1:0]               error_code,
  output logic [CountOutWidth-1:0] byte_count
);

  logic    valid_q;
  result_t res_q;

  // the slot frees in the same cycle its beat is taken
  assign slot_free = !valid_q || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign out_valid    = valid_q;
  assign event_res    = res_q.event_res;
  assign load_address = res_q.load_address;
  assign data_byte    = res_q.data_byte;
  assign error_code   = res_q.error_code;
  assign byte_count   = res_q.byte_count;

endmodule
